FILE: rtl/core/msa_pkg.sv
package msa_pkg;

   localparam int DEPTH_DEF      = 32;
   localparam int MAX_STACKS_DEF = 16;

   localparam int ACT_W      = 2;
   localparam int IDX_W      = 4;
   localparam int VAL_W      = 32;
   localparam int STAT_W     = 2;
   localparam int CFG_W      = 5;
   localparam int REQ_DATA_W = 40;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH = 2'd0,
      ACT_POP  = 2'd1,
      ACT_LIST = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

endpackage

FILE: rtl/core/multi_stack_shared_array.sv
// Several stacks sharing one word memory, each in a fixed segment.
// req channel: one beat is one operation (push, pop or list) on one stack.
// rsp channel: push, pop, overflow, underflow and bad index give one beat
// with tlast high; a list gives one beat per element, bottom to top, tlast
// on the top one. tuser carries the status code.
// csr channel: writes the stack count; the segment size is then worked out
// by a bit-serial divider and every stack is emptied. req is held off while
// that runs. Sequence: an operation goes accept, lookup, memory access,
// result, and the next item can be taken once the result beat is loaded. A
// bad index skips the memory step; an unused action code gives no beat and
// frees req after the lookup. A list reads each element and then loads its
// beat, one element at a time, since the single read port is registered.
// One item is in work at a time; req_tready is low until its last beat is
// in the output register.
// A stalled rsp holds its beat; the sequencer waits until the output
// register frees up. Reset empties all stacks, selects one stack of DEPTH
// words, and drops any pending beat. Memory contents are not cleared.
module multi_stack_shared_array #(
   parameter int DEPTH      = msa_pkg::DEPTH_DEF,
   parameter int MAX_STACKS = msa_pkg::MAX_STACKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // action [1:0], stack_index [5:2], push_value [37:6], zero [39:38]
   input  logic [msa_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // data [31:0]
   output logic [msa_pkg::VAL_W-1:0]      rsp_tdata,
   // status [1:0]
   output logic [msa_pkg::STAT_W-1:0]     rsp_tuser,
   output logic                           rsp_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [msa_pkg::CFG_W-1:0]      csr_data,
   input  logic                           csr_valid,
   output logic                           csr_ready
);
   import msa_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SW    = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
   localparam int LIM   = (MAX_STACKS < DEPTH) ? MAX_STACKS : DEPTH;
   localparam int LIM_C = (LIM < 31) ? LIM : 31;
   localparam logic [CFG_W-1:0] LIM_V   = CFG_W'(LIM_C);
   localparam logic [CW-1:0]    DEPTH_V = CW'(DEPTH);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_DIV   = 6'b000010,
      S_CHECK = 6'b000100,
      S_OP    = 6'b001000,
      S_LREAD = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   action_type       act_ff, act_in;
   logic [IDX_W-1:0] sidx_ff, sidx_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [CFG_W-1:0] nstk_ff, nstk_in;
   logic [CW-1:0]    seg_ff, seg_in;
   logic [CW-1:0]    base_ff, base_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [CW-1:0]    fill_ff [MAX_STACKS];
   logic [CW-1:0]    fill_in [MAX_STACKS];
   status_type       em_stat_ff, em_stat_in;
   logic             em_last_ff, em_last_in;
   logic             em_mem_ff, em_mem_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_stat_ff, rsp_stat_in;
   logic [VAL_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;
   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr, rd_addr;

   logic             req_acc, csr_acc, out_free, div_done;
   logic [CFG_W-1:0] cfg_v;
   logic [CW-1:0]    div_q, cap;
   logic [SW-1:0]    fi;
   logic             in_range, last_seg;

   assign csr_ready  = state_ff == S_IDLE;
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // zero counts as one stack, too many saturates
   assign cfg_v = (csr_data == '0) ? CFG_W'(1) : ((csr_data > LIM_V) ? LIM_V : csr_data);

   msa_div #(
      .DW       (CW),
      .DIVIDEND (DEPTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_acc),
      .divisor  (cfg_v),
      .done     (div_done),
      .quotient (div_q)
   );

   assign fi       = SW'(sidx_ff);
   assign in_range = CFG_W'(sidx_ff) < nstk_ff;
   assign last_seg = (CFG_W'(sidx_ff) + CFG_W'(1)) == nstk_ff;
   // last segment also holds the remainder words
   assign cap      = last_seg ? (DEPTH_V - base_ff) : seg_ff;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      sidx_in      = sidx_ff;
      val_in       = val_ff;
      nstk_in      = nstk_ff;
      seg_in       = seg_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      fill_in      = fill_ff;
      em_stat_in   = em_stat_ff;
      em_last_in   = em_last_ff;
      em_mem_in    = em_mem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(base_ff + cnt_ff);
      rd_en        = 1'b0;
      rd_addr      = AW'(base_ff + cnt_ff - CW'(1));

      case (state_ff)
         S_IDLE: begin
            if (csr_acc) begin
               nstk_in = cfg_v;
               for (int i = 0; i < MAX_STACKS; i++) begin
                  fill_in[i] = '0;
               end
               state_in = S_DIV;
            end else if (req_acc) begin
               act_in   = action_type'(req_tdata[ACT_W-1:0]);
               sidx_in  = req_tdata[ACT_W+IDX_W-1:ACT_W];
               val_in   = req_tdata[ACT_W+IDX_W+VAL_W-1:ACT_W+IDX_W];
               state_in = S_CHECK;
            end
         end
         S_DIV: begin
            if (div_done) begin
               seg_in   = div_q;
               state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            em_mem_in  = 1'b0;
            em_last_in = 1'b1;
            if (act_ff == ACT_NONE) begin
               state_in = S_IDLE;
            end else if (!in_range) begin
               em_stat_in = ST_RANGE;
               state_in   = S_EMIT;
            end else begin
               base_in  = CW'(sidx_ff * seg_ff);
               cnt_in   = fill_ff[fi];
               state_in = S_OP;
            end
         end
         S_OP: begin
            em_stat_in = ST_OK;
            state_in   = S_EMIT;
            case (act_ff)
               ACT_PUSH: begin
                  if (cnt_ff >= cap) begin
                     em_stat_in = ST_OVERFLOW;
                  end else begin
                     wr_en       = 1'b1;
                     fill_in[fi] = cnt_ff + CW'(1);
                  end
               end
               ACT_POP: begin
                  if (cnt_ff == '0) begin
                     em_stat_in = ST_UNDERFLOW;
                  end else begin
                     rd_en       = 1'b1;
                     em_mem_in   = 1'b1;
                     fill_in[fi] = cnt_ff - CW'(1);
                  end
               end
               ACT_LIST: begin
                  if (cnt_ff == '0) begin
                     em_stat_in = ST_UNDERFLOW;
                  end else begin
                     k_in     = '0;
                     state_in = S_LREAD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LREAD: begin
            rd_en      = 1'b1;
            rd_addr    = AW'(base_ff + k_ff);
            em_stat_in = ST_OK;
            em_mem_in  = 1'b1;
            em_last_in = (k_ff + CW'(1)) == cnt_ff;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = em_stat_ff;
               rsp_data_in  = em_mem_ff ? rd_data_ff : '0;
               rsp_last_in  = em_last_ff;
               if (em_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = S_LREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nstk_ff      <= CFG_W'(1);
         seg_ff       <= DEPTH_V;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_STACKS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         nstk_ff      <= nstk_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      sidx_ff     <= sidx_in;
      val_ff      <= val_in;
      base_ff     <= base_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      em_stat_ff  <= em_stat_in;
      em_last_ff  <= em_last_in;
      em_mem_ff   <= em_mem_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= val_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/core/msa_div.sv
module msa_div #(
   parameter int DW       = 6,
   parameter int DIVIDEND = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [msa_pkg::CFG_W-1:0] divisor,
   output logic                      done,
   output logic [DW-1:0]             quotient
);
   import msa_pkg::*;

   localparam int SCW = $clog2(DW + 1);

   logic [DW-1:0]    num_ff, num_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [CFG_W-1:0] rem_ff, rem_in;
   logic [CFG_W-1:0] div_ff, div_in;
   logic [SCW-1:0]   step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CFG_W:0]   trial;
   logic             fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, num_ff[DW-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = DW'(DIVIDEND);
         quo_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         step_in = SCW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? CFG_W'(trial - {1'b0, div_ff}) : CFG_W'(trial);
         num_in  = {num_ff[DW-2:0], 1'b0};
         quo_in  = {quo_ff[DW-2:0], fits};
         step_in = step_ff - SCW'(1);
         if (step_ff == SCW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: tb/multi_stack_shared_array_tb.sv
module multi_stack_shared_array_tb;
   import msa_pkg::*;

   typedef struct {
      status_type  status;
      logic [31:0] data;
      logic        last;
   } rsp_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [VAL_W-1:0]      rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CFG_W-1:0]      csr_data = '0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;

   // predicted contents of the shared memory and the per-stack fill
   logic [31:0] stack_mem [DEPTH_DEF];
   int          stack_fill [MAX_STACKS_DEF];
   int          seg_words = DEPTH_DEF;
   int          active_stacks = 1;

   rsp_beat_type pending_beats [$];
   int           beat_errors = 0;
   int           burst_left = 0;

   logic [31:0] ready_mask = '1;
   logic [31:0] ready_phase = '0;

   multi_stack_shared_array dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #30000000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void expect_beat(status_type st, logic [31:0] d, logic l);
      rsp_beat_type b;
      b.status = st;
      b.data   = d;
      b.last   = l;
      pending_beats.push_back(b);
   endfunction

   function automatic void set_stack_count(logic [4:0] v);
      int n;
      n = (v == 0) ? 1 : int'(v);
      if (n > MAX_STACKS_DEF) n = MAX_STACKS_DEF;
      if (n > DEPTH_DEF) n = DEPTH_DEF;
      active_stacks = n;
      seg_words = DEPTH_DEF / n;
      for (int i = 0; i < MAX_STACKS_DEF; i++) stack_fill[i] = 0;
   endfunction

   function automatic void model_stack_op(action_type act, int idx, logic [31:0] val);
      int base;
      int cap;
      int n;
      if (act == ACT_NONE) return;
      if (idx >= active_stacks) begin
         expect_beat(ST_RANGE, '0, 1'b1);
         return;
      end
      base = idx * seg_words;
      n = stack_fill[idx];
      // the top stack also owns the remainder words
      cap = (idx == active_stacks - 1) ? DEPTH_DEF - base : seg_words;
      if (act == ACT_PUSH) begin
         if (n >= cap) begin
            expect_beat(ST_OVERFLOW, '0, 1'b1);
         end else begin
            stack_mem[(base + n) % DEPTH_DEF] = val;
            stack_fill[idx] = n + 1;
            expect_beat(ST_OK, '0, 1'b1);
         end
      end else if (n == 0) begin
         expect_beat(ST_UNDERFLOW, '0, 1'b1);
      end else if (act == ACT_POP) begin
         stack_fill[idx] = n - 1;
         expect_beat(ST_OK, stack_mem[(base + n - 1) % DEPTH_DEF], 1'b1);
      end else begin
         for (int k = 0; k < n; k++)
            expect_beat(ST_OK, stack_mem[(base + k) % DEPTH_DEF], k == n - 1);
      end
   endfunction

   task automatic send_op(action_type act, logic [3:0] idx, logic [31:0] val);
      req_tdata  <= {2'b00, val, idx, act};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_stack_op(act, idx, val);
   endtask

   // burst pacing on the request side
   task automatic sender_gap();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
      end
   endtask

   // hold requests until every predicted beat is out, then let the block settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_stack_count(logic [4:0] v);
      drain_results();
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      set_stack_count(v);
   endtask

   task automatic test_empty_and_full();
      write_stack_count(5'd16);
      send_op(ACT_POP, 4'd0, 32'h0);
      sender_gap();
      send_op(ACT_LIST, 4'd0, 32'h0);
      sender_gap();
      send_op(ACT_PUSH, 4'd0, 32'h8000_0000);
      sender_gap();
      send_op(ACT_PUSH, 4'd0, 32'h7fff_ffff);
      sender_gap();
      send_op(ACT_PUSH, 4'd0, 32'h0000_1234);
      sender_gap();
      send_op(ACT_LIST, 4'd0, 32'h0);
      sender_gap();
      send_op(ACT_POP, 4'd0, 32'h0);
      sender_gap();
      send_op(ACT_PUSH, 4'd15, 32'hffff_ffff);
      sender_gap();
      send_op(ACT_PUSH, 4'd15, 32'h0);
      sender_gap();
      send_op(ACT_PUSH, 4'd15, 32'h5);
      sender_gap();
      send_op(ACT_LIST, 4'd15, 32'h0);
      sender_gap();
      send_op(ACT_POP, 4'd15, 32'h0);
      sender_gap();
   endtask

   task automatic test_range_and_ignore();
      // a zero count behaves as a single stack
      write_stack_count(5'd0);
      send_op(ACT_POP, 4'd1, 32'h0);
      sender_gap();
      send_op(ACT_LIST, 4'd15, 32'h0);
      sender_gap();
      send_op(ACT_PUSH, 4'd8, 32'hdead_beef);
      sender_gap();
      send_op(ACT_NONE, 4'd0, 32'h1111_1111);
      sender_gap();
      send_op(ACT_NONE, 4'd9, 32'h0);
      sender_gap();
      send_op(ACT_PUSH, 4'd0, 32'ha5a5_a5a5);
      sender_gap();
      send_op(ACT_LIST, 4'd0, 32'h0);
      sender_gap();
   endtask

   task automatic test_stack_count_limits();
      // an oversize count saturates at the stack limit
      write_stack_count(5'd31);
      send_op(ACT_PUSH, 4'd15, 32'h5a5a_5a5a);
      sender_gap();
      send_op(ACT_POP, 4'd15, 32'h0);
      sender_gap();
      send_op(ACT_POP, 4'd14, 32'h0);
      sender_gap();
   endtask

   task automatic test_random_mix();
      logic [4:0] counts [10] = '{5'd1, 5'd16, 5'd3, 5'd7, 5'd31, 5'd2, 5'd11,
                                 5'd0, 5'd20, 5'd5};
      int         done_ops;
      int         r;
      action_type act;
      logic [3:0] idx;
      for (int p = 0; p < 10; p++) begin
         write_stack_count(counts[p]);
         done_ops = 0;
         while (done_ops < 39) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               act = ACT_NONE;
               idx = 4'($urandom_range(0, 15));
            end else begin
               done_ops++;
               if (r < 13) begin
                  act = action_type'($urandom_range(0, 2));
                  idx = (active_stacks < MAX_STACKS_DEF)
                        ? 4'($urandom_range(active_stacks, 15))
                        : 4'($urandom_range(0, 15));
               end else begin
                  idx = 4'($urandom_range(0, active_stacks - 1));
                  r = $urandom_range(0, 99);
                  act = (r < 50) ? ACT_PUSH : (r < 78) ? ACT_POP : ACT_LIST;
               end
            end
            send_op(act, idx, $urandom);
            sender_gap();
            if (done_ops == 21 && act != ACT_NONE) drain_results();
         end
      end
   endtask

   // receiver back-pressure: a random mask, chosen anew whenever the low byte of the phase counter is zero
   always @(posedge clock) begin
      ready_phase <= ready_phase + 1;
      if (ready_phase[7:0] == 8'd0) begin
         case ($urandom_range(0, 3))
            0: ready_mask <= '1;
            1: ready_mask <= $urandom;
            2: ready_mask <= $urandom | $urandom;
            default: ready_mask <= 32'h0f0f_0f0f;
         endcase
      end
      rsp_tready <= ready_mask[ready_phase[4:0]];
   end

   always @(posedge clock) begin : rsp_check
      rsp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected beat: status %0d data %h last %0b",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            beat_errors++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               beat_errors++;
            end
            if (rsp_tdata !== want.data) begin
               $error("data: expected %h, got %h", want.data, rsp_tdata);
               beat_errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_tlast);
               beat_errors++;
            end
         end
      end
   end

   initial begin
      int w;
      set_stack_count(5'd1);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_full();
      test_range_and_ignore();
      test_stack_count_limits();
      test_random_mix();
      req_tvalid <= 1'b0;
      for (w = 0; w < 20000 && pending_beats.size() != 0; w++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_beats.size() != 0)
         $error("%0d expected beats never arrived", pending_beats.size());
      if (beat_errors == 0 && pending_beats.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
